// ===== hdl/svpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the state vector Pauli engine.
// No dependencies; imported by svpe_meas, the top level and the testbench.
package svpe_pkg;

  localparam int MODE_W   = 2;
  localparam int TARGET_W = 4;
  localparam int COUNT_W  = 4;
  localparam int INDEX_W  = 4;
  localparam int PROB_W   = 32;
  localparam int PROB_FRAC = 30;
  localparam int NORM_W   = PROB_W + 2;

  localparam logic [MODE_W-1:0] MODE_X       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_Y       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  localparam logic [COUNT_W-1:0] QUBIT_COUNT_RESET = 4'd10;

endpackage

// ===== hdl/svpe_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module svpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/svpe_meas.sv =====
`timescale 1ns / 1ps
// Measurement datapath: squared magnitude of each amplitude and one saturating
// accumulator per qubit. Depends on svpe_pkg.
module svpe_meas
  import svpe_pkg::*;
#(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic                                in_valid,
  input  logic [MAX_QUBITS-1:0]               addr,
  input  logic signed [AMP_WIDTH-1:0]         re,
  input  logic signed [AMP_WIDTH-1:0]         im,
  output logic                                busy,
  output logic [MAX_QUBITS-1:0][PROB_W-1:0]   acc
);

  localparam int SqW    = 2 * AMP_WIDTH;
  localparam int SqFrac = 2 * (AMP_WIDTH - 2);
  localparam int Lsh    = (SqFrac <= PROB_FRAC) ? PROB_FRAC - SqFrac : 0;
  localparam int Rsh    = (SqFrac > PROB_FRAC) ? SqFrac - PROB_FRAC : 0;
  localparam int TotW   = PROB_W + 3;

  logic                  s1_valid;
  logic [MAX_QUBITS-1:0] s1_addr;
  logic signed [SqW-1:0] sq_re;
  logic signed [SqW-1:0] sq_im;
  logic                  s2_valid;
  logic [MAX_QUBITS-1:0] s2_addr;
  logic [NORM_W-1:0]     norm;
  logic [SqW-1:0]        sum;
  logic [63:0]           wide;

  assign sum  = unsigned'(sq_re) + unsigned'(sq_im);
  assign wide = 64'(sum);
  assign busy = s1_valid | s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
    s1_addr <= addr;
    sq_re   <= re * re;
    sq_im   <= im * im;
    s2_addr <= s1_addr;
    norm    <= NORM_W'((wide << Lsh) >> Rsh);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_QUBITS; j++) begin
      if (clear) begin
        acc[j] <= '0;
      end else if (s2_valid && s2_addr[j]) begin
        if ((TotW'(acc[j]) + TotW'(norm)) > TotW'({PROB_W{1'b1}})) begin
          acc[j] <= '1;
        end else begin
          acc[j] <= acc[j] + PROB_W'(norm);
        end
      end
    end
  end

endmodule

// ===== hdl/state_vector_pauli_engine_unit.sv =====
`timescale 1ns / 1ps
// Top level of the state vector Pauli engine: command control, store banks, results.
// Depends on svpe_pkg, svpe_ram and svpe_meas.
//
// The engine holds 2^MAX_QUBITS complex amplitudes in two RAM banks and runs one
// command at a time. After reset it writes the initial state into the active
// bank and takes no command meanwhile. An X or Y gate streams every entry of the
// active bank through one read port into the other bank at the swapped index,
// then makes that bank active and gives its single result word. A measurement
// streams the active bank once through a squaring pipeline into one accumulator
// per qubit and then gives one word per qubit in use, one per cycle while the
// output is not stalled. Invalid targets and unknown modes go straight to the
// post state, which gives a status word. The single read port of a bank, one
// entry per cycle, sets the length of every gate and measurement.
module state_vector_pauli_engine_unit
  import svpe_pkg::*;
#(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   mode,
  input  logic [TARGET_W-1:0] qubit_sel,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                status,
  output logic [INDEX_W-1:0]  qubit_index,
  output logic [PROB_W-1:0]   probability,
  output logic                last
);

  localparam int AW    = MAX_QUBITS;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = 2 * AMP_WIDTH;
  localparam int CW    = $clog2(MAX_QUBITS + 1);
  localparam int IW    = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
  localparam logic signed [AMP_WIDTH-1:0] AmpMax = {1'b0, {(AMP_WIDTH - 1){1'b1}}};
  localparam logic signed [AMP_WIDTH-1:0] AmpMin = {1'b1, {(AMP_WIDTH - 1){1'b0}}};
  localparam logic [DW-1:0] AmpOne = DW'(1) << (DW - 2);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_GATE, S_GATE_END, S_MEAS, S_MEAS_END, S_EMIT, S_POST
  } state_t;

  function automatic logic signed [AMP_WIDTH-1:0] sat_neg(
    input logic signed [AMP_WIDTH-1:0] v
  );
    return (v == AmpMin) ? AmpMax : -v;
  endfunction

  state_t                    state;
  logic [COUNT_W-1:0]        qubit_count;
  logic [CW-1:0]             n_eff;
  logic [CW-1:0]             n_reg;
  logic [AW-1:0]             cnt;
  logic [AW-1:0]             gate_bit;
  logic                      is_y;
  logic                      bank;
  logic                      p1_valid;
  logic                      p1_gate;
  logic [AW-1:0]             p1_addr;
  logic [IW-1:0]             emit_idx;
  logic                      post_status;
  logic                      out_free;
  logic                      accept;
  logic                      meas_clear;
  logic                      meas_busy;
  logic [MAX_QUBITS-1:0][PROB_W-1:0] acc;
  logic [DW-1:0]             rdata0;
  logic [DW-1:0]             rdata1;
  logic [DW-1:0]             rd;
  logic signed [AMP_WIDTH-1:0] rd_re;
  logic signed [AMP_WIDTH-1:0] rd_im;
  logic [DW-1:0]             gate_data;
  logic                      gate_wr;
  logic                      clear_wr;
  logic                      we0;
  logic                      we1;
  logic [AW-1:0]             waddr;
  logic [DW-1:0]             wdata;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign meas_clear = accept && (mode == MODE_MEASURE);
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    if (qubit_count == '0) begin
      n_eff = CW'(1);
    end else if (int'(qubit_count) > MAX_QUBITS) begin
      n_eff = CW'(MAX_QUBITS);
    end else begin
      n_eff = CW'(qubit_count);
    end
  end

  assign rd    = bank ? rdata1 : rdata0;
  assign rd_re = rd[DW-1:AMP_WIDTH];
  assign rd_im = rd[AMP_WIDTH-1:0];

  always_comb begin
    if (!is_y) begin
      gate_data = rd;
    end else if (!(|(p1_addr & gate_bit))) begin
      gate_data = {sat_neg(rd_im), rd_re};
    end else begin
      gate_data = {rd_im, sat_neg(rd_re)};
    end
  end

  assign gate_wr  = p1_valid && p1_gate;
  assign clear_wr = (state == S_CLEAR);
  assign we0      = (clear_wr && !bank) || (gate_wr && bank);
  assign we1      = (clear_wr && bank) || (gate_wr && !bank);
  assign waddr    = clear_wr ? cnt : (p1_addr ^ gate_bit);
  assign wdata    = clear_wr ? ((cnt == '0) ? AmpOne : '0) : gate_data;

  svpe_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt),
    .rdata (rdata0)
  );

  svpe_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt),
    .rdata (rdata1)
  );

  svpe_meas #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_meas (
    .clk      (clk),
    .rst      (rst),
    .clear    (meas_clear),
    .in_valid (p1_valid && !p1_gate),
    .addr     (p1_addr),
    .re       (rd_re),
    .im       (rd_im),
    .busy     (meas_busy),
    .acc      (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      qubit_count <= QUBIT_COUNT_RESET;
    end else if (cfg_we) begin
      qubit_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      bank      <= 1'b0;
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && state != S_EMIT && state != S_POST) begin
        out_valid <= 1'b0;
      end
      p1_valid <= (state == S_GATE) || (state == S_MEAS);
      p1_gate  <= (state == S_GATE);
      p1_addr  <= cnt;
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cnt      <= '0;
            n_reg    <= n_eff;
            emit_idx <= '0;
            is_y     <= (mode == MODE_Y);
            gate_bit <= AW'(1) << (qubit_sel - 4'd1);
            if (mode == MODE_X || mode == MODE_Y) begin
              if (qubit_sel == '0 || int'(qubit_sel) > int'(n_eff)) begin
                post_status <= STATUS_BAD;
                state       <= S_POST;
              end else begin
                state <= S_GATE;
              end
            end else if (mode == MODE_MEASURE) begin
              state <= S_MEAS;
            end else begin
              post_status <= STATUS_BAD;
              state       <= S_POST;
            end
          end
        end
        S_GATE: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= S_GATE_END;
          end
        end
        S_GATE_END: begin
          bank        <= !bank;
          post_status <= STATUS_OK;
          state       <= S_POST;
        end
        S_MEAS: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= S_MEAS_END;
          end
        end
        S_MEAS_END: begin
          if (!p1_valid && !meas_busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= STATUS_OK;
            qubit_index <= INDEX_W'(emit_idx);
            probability <= acc[emit_idx];
            last        <= (int'(emit_idx) + 1 == int'(n_reg));
            emit_idx    <= emit_idx + 1'b1;
            if (int'(emit_idx) + 1 == int'(n_reg)) begin
              state <= S_IDLE;
            end
          end
        end
        S_POST: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= post_status;
            qubit_index <= '0;
            probability <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_gate_flips_bank: assert property (@(posedge clk) disable iff (rst)
    state == S_GATE_END |=> bank != $past(bank))
    else $error("gate walk ended without switching the active bank");

  a_meas_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_MEAS || state == S_MEAS_END) |-> !we0 && !we1)
    else $error("store written during a measurement");

  a_emit_after_drain: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> !meas_busy && !p1_valid)
    else $error("measurement word sent before the pipeline drained");
`endif

endmodule

// ===== sim/tb_state_vector_pauli_engine_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for state_vector_pauli_engine_unit: X, Y and measure commands
// checked word by word against an in-bench model of the amplitude store.
// Depends on svpe_pkg and the engine RTL; needs no files or arguments.
module tb_state_vector_pauli_engine_unit;
  import svpe_pkg::*;

  localparam int MAX_QUBITS  = 10;
  localparam int AMP_WIDTH   = 16;
  localparam int FRAC_BITS   = AMP_WIDTH - 2;
  localparam int STORE_DEPTH = 1 << MAX_QUBITS;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 40;

  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

  localparam logic signed [AMP_WIDTH-1:0] AMP_MOST_NEG = {1'b1, {(AMP_WIDTH-1){1'b0}}};
  localparam logic signed [AMP_WIDTH-1:0] AMP_MOST_POS = {1'b0, {(AMP_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic                status;
    logic [INDEX_W-1:0]  qubit;
    logic [PROB_W-1:0]   prob;
    logic                last;
  } result_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   mode = MODE_X;
  logic [TARGET_W-1:0] qubit_sel = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                status;
  logic [INDEX_W-1:0]  qubit_index;
  logic [PROB_W-1:0]   probability;
  logic                last;

  logic signed [AMP_WIDTH-1:0] amp_re [STORE_DEPTH];
  logic signed [AMP_WIDTH-1:0] amp_im [STORE_DEPTH];
  logic signed [AMP_WIDTH-1:0] moved_re [STORE_DEPTH];
  logic signed [AMP_WIDTH-1:0] moved_im [STORE_DEPTH];
  logic [COUNT_W-1:0]          qubit_count_reg;

  result_word_t pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  logic         stall_enable = 1'b1;

  state_vector_pauli_engine_unit #(
    .MAX_QUBITS(MAX_QUBITS),
    .AMP_WIDTH (AMP_WIDTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .qubit_sel   (qubit_sel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .qubit_index (qubit_index),
    .probability (probability),
    .last        (last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !(stall_enable && $urandom_range(99) < 6);
  end

  function automatic int unsigned qubits_in_use();
    if (qubit_count_reg == 0) return 1;
    if (qubit_count_reg > MAX_QUBITS) return MAX_QUBITS;
    return qubit_count_reg;
  endfunction

  function automatic logic signed [AMP_WIDTH-1:0] negate_sat(
    input logic signed [AMP_WIDTH-1:0] v
  );
    if (v == AMP_MOST_NEG) return AMP_MOST_POS;
    return -v;
  endfunction

  function automatic longint unsigned energy_q30(
    input logic signed [AMP_WIDTH-1:0] re,
    input logic signed [AMP_WIDTH-1:0] im
  );
    longint a;
    longint b;
    longint unsigned s;
    a = re;
    b = im;
    if (a < 0) a = -a;
    if (b < 0) b = -b;
    s = a * a + b * b;
    if (2 * FRAC_BITS <= PROB_FRAC) return s << (PROB_FRAC - 2 * FRAC_BITS);
    return s >> (2 * FRAC_BITS - PROB_FRAC);
  endfunction

  task automatic enqueue_word(input result_word_t w);
    pending_results.insert(pending_results.size(), w);
  endtask

  task automatic push_status_word(input logic st);
    enqueue_word('{status: st, qubit: '0, prob: '0, last: 1'b1});
  endtask

  task automatic apply_pauli(input int unsigned target, input logic is_y);
    int unsigned flip;
    int unsigned dst;
    flip = 1 << (target - 1);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      dst = (i ^ flip) & (STORE_DEPTH - 1);
      if (!is_y) begin
        moved_re[dst] = amp_re[i];
        moved_im[dst] = amp_im[i];
      end else if ((dst & flip) != 0) begin
        moved_re[dst] = negate_sat(amp_im[i]);
        moved_im[dst] = amp_re[i];
      end else begin
        moved_re[dst] = amp_im[i];
        moved_im[dst] = negate_sat(amp_re[i]);
      end
    end
    amp_re = moved_re;
    amp_im = moved_im;
  endtask

  task automatic measure_qubits();
    longint unsigned acc [MAX_QUBITS];
    longint unsigned e;
    int unsigned n;
    n = qubits_in_use();
    for (int j = 0; j < MAX_QUBITS; j++) acc[j] = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      e = energy_q30(amp_re[i], amp_im[i]);
      for (int j = 0; j < n; j++) begin
        if (((i >> j) & 1) != 0) begin
          acc[j] += e;
          if (acc[j] > 64'hFFFF_FFFF) acc[j] = 64'hFFFF_FFFF;
        end
      end
    end
    for (int j = 0; j < n; j++) begin
      enqueue_word('{status: STATUS_OK, qubit: j[INDEX_W-1:0],
                     prob: acc[j][PROB_W-1:0], last: (j == n - 1)});
    end
  endtask

  task automatic predict_command(input logic [MODE_W-1:0] m, input logic [TARGET_W-1:0] t);
    int unsigned n;
    n = qubits_in_use();
    case (m)
      MODE_X, MODE_Y: begin
        if (t == 0 || t > n) begin
          push_status_word(STATUS_BAD);
        end else begin
          apply_pauli(t, m == MODE_Y);
          push_status_word(STATUS_OK);
        end
      end
      MODE_MEASURE: measure_qubits();
      default: push_status_word(STATUS_BAD);
    endcase
  endtask

  // The payload is fixed from the step valid rises, so the prediction is made there.
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [TARGET_W-1:0] t);
    while (stall_enable && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    qubit_sel <= t;
    predict_command(m, t);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_qubit_count(input logic [COUNT_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    qubit_count_reg = v;
  endtask

  task automatic report_word(input string what, input result_word_t want,
                             input result_word_t got);
    if (mismatch_count < 10) begin
      $display("%s at cycle %0d: expected status=%0d qubit=%0d prob=%h last=%0d",
               what, cycle_count, want.status, want.qubit, want.prob, want.last);
      $display("  got status=%0d qubit=%0d prob=%h last=%0d",
               got.status, got.qubit, got.prob, got.last);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{status: status, qubit: qubit_index, prob: probability, last: last};
      if (pending_results.size() == 0) begin
        report_word("unexpected word", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.qubit !== want.qubit ||
            got.prob !== want.prob || got.last !== want.last) begin
          report_word("mismatch", want, got);
        end
      end
    end
  end

  task automatic test_reset_state();
    send_word(MODE_MEASURE, 4'd0);
    send_word(MODE_X, 4'd1);
    send_word(MODE_MEASURE, 4'd5);
    send_word(MODE_X, 4'd10);
    send_word(MODE_Y, 4'd10);
    send_word(MODE_MEASURE, 4'd0);
    send_word(MODE_Y, 4'd1);
    send_word(MODE_MEASURE, 4'd15);
  endtask

  task automatic test_bad_commands();
    send_word(MODE_X, 4'd0);
    send_word(MODE_Y, 4'd0);
    send_word(MODE_X, 4'd11);
    send_word(MODE_Y, 4'd15);
    send_word(MODE_UNKNOWN, 4'd0);
    send_word(MODE_UNKNOWN, 4'd15);
  endtask

  task automatic test_count_extremes();
    drain_results();
    write_qubit_count(4'd0);
    send_word(MODE_MEASURE, 4'd0);
    send_word(MODE_X, 4'd1);
    send_word(MODE_Y, 4'd2);
    send_word(MODE_MEASURE, 4'd0);
    drain_results();
    write_qubit_count(4'd15);
    send_word(MODE_Y, 4'd10);
    send_word(MODE_MEASURE, 4'd0);
    send_word(MODE_X, 4'd11);
    drain_results();
    write_qubit_count(4'd1);
    send_word(MODE_Y, 4'd1);
    send_word(MODE_MEASURE, 4'd0);
  endtask

  task automatic test_random_commands();
    logic [COUNT_W-1:0] phase_counts [8];
    logic [MODE_W-1:0]  m;
    logic [TARGET_W-1:0] t;
    int unsigned pick;
    phase_counts = '{4'd3, 4'd15, 4'd0, 4'd7, 4'd1, 4'd10, 4'd12, 4'd5};
    for (int p = 0; p < 8; p++) begin
      drain_results();
      write_qubit_count(phase_counts[p]);
      stall_enable = !(p == 3 || p == 4);
      for (int k = 0; k < 43; k++) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          m = $urandom_range(1) ? MODE_Y : MODE_X;
          t = $urandom_range(qubits_in_use(), 1);
        end else if (pick < 80) begin
          m = MODE_MEASURE;
          t = $urandom_range(15);
        end else if (pick < 92) begin
          m = $urandom_range(1) ? MODE_Y : MODE_X;
          t = $urandom_range(15);
        end else begin
          m = MODE_UNKNOWN;
          t = $urandom_range(15);
        end
        send_word(m, t);
        if (p == 1 && k == 20) drain_results();
      end
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      amp_re[i] = '0;
      amp_im[i] = '0;
    end
    amp_re[0] = 1 << FRAC_BITS;
    qubit_count_reg = QUBIT_COUNT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_bad_commands();
    test_count_extremes();
    test_random_commands();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
